// File: hw/rtl/elgamal_signature_verify_top_macros.svh
// Assertion macros shared by the signature verifier RTL.
`ifndef ELGAMAL_SIGNATURE_VERIFY_TOP_MACROS_SVH
`define ELGAMAL_SIGNATURE_VERIFY_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled in reset.
`define ESV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and disabled in reset.
`define ESV_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/esv_pkg.sv
// Shared types, codes and the microcode program of the signature verifier.
`default_nettype none

package esv_pkg;

    localparam int FIELD_W      = 31;
    localparam int MOD_BITS_DEF = 31;
    localparam int CFG_IDX_W    = 2;
    localparam int PC_W         = 5;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GENERATOR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_VALUE = 2'd2;

    localparam logic [FIELD_W-1:0] MODULUS_RST = 31'd2;

    typedef logic [PC_W-1:0] pc_t;
    typedef logic [1:0]      asel_t;
    typedef logic [2:0]      bsel_t;
    typedef logic [1:0]      dst_t;
    typedef logic [1:0]      expld_t;
    typedef logic [2:0]      jc_t;
    typedef logic [1:0]      fin_t;

    // Multiplicand select. Every choice is already reduced below the modulus.
    localparam asel_t ASEL_ONE  = 2'd0;
    localparam asel_t ASEL_ACC  = 2'd1;
    localparam asel_t ASEL_BASE = 2'd2;
    localparam asel_t ASEL_LHS  = 2'd3;

    // Multiplier select. Any value up to the operand width is allowed.
    localparam bsel_t BSEL_BETA = 3'd0;
    localparam bsel_t BSEL_GEN  = 3'd1;
    localparam bsel_t BSEL_GAM  = 3'd2;
    localparam bsel_t BSEL_BASE = 3'd3;
    localparam bsel_t BSEL_ACC  = 3'd4;

    localparam dst_t DST_ACC  = 2'd0;
    localparam dst_t DST_BASE = 2'd1;
    localparam dst_t DST_LHS  = 2'd2;

    localparam expld_t EXPLD_NONE = 2'd0;
    localparam expld_t EXPLD_GAM  = 2'd1;
    localparam expld_t EXPLD_DEL  = 2'd2;
    localparam expld_t EXPLD_MSG  = 2'd3;

    localparam jc_t JC_NEXT    = 3'd0;
    localparam jc_t JC_ALWAYS  = 3'd1;
    localparam jc_t JC_EXPZ    = 3'd2;
    localparam jc_t JC_EVEN    = 3'd3;
    localparam jc_t JC_BADGAM  = 3'd4;

    localparam fin_t FIN_NONE   = 2'd0;
    localparam fin_t FIN_CHECK  = 2'd1;
    localparam fin_t FIN_REJECT = 2'd2;

    // Jump targets of the program.
    localparam pc_t PC_LOOP1  = 5'd2;
    localparam pc_t PC_SEG2   = 5'd7;
    localparam pc_t PC_LOOP2  = 5'd8;
    localparam pc_t PC_COMB   = 5'd13;
    localparam pc_t PC_LOOP3  = 5'd15;
    localparam pc_t PC_CHECK  = 5'd20;
    localparam pc_t PC_REJECT = 5'd21;

    typedef struct packed {
        logic   is_mul;
        asel_t  a_sel;
        bsel_t  b_sel;
        dst_t   dst;
        expld_t exp_ld;
        logic   exp_shift;
        logic   acc_one;
        logic   lhs_from_acc;
        jc_t    jc;
        pc_t    target;
        fin_t   fin;
    } ucw_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic ok;
    } core_stat_t;

    function automatic ucw_t uc_mul(asel_t a, bsel_t b, dst_t d);
        ucw_t w;
        w        = '0;
        w.is_mul = 1'b1;
        w.a_sel  = a;
        w.b_sel  = b;
        w.dst    = d;
        return w;
    endfunction

    function automatic ucw_t uc_jump(jc_t c, pc_t t);
        ucw_t w;
        w        = '0;
        w.jc     = c;
        w.target = t;
        return w;
    endfunction

    function automatic ucw_t uc_fin(fin_t f);
        ucw_t w;
        w     = '0;
        w.fin = f;
        return w;
    endfunction

    // The program: beta^gamma into lhs, times gamma^delta, then g^m in acc.
    function automatic ucw_t ucode(pc_t pc);
        ucw_t w;
        w = uc_fin(FIN_REJECT);
        case (pc)
            5'd0: w = uc_jump(JC_BADGAM, PC_REJECT);
            5'd1:
            begin
                w         = uc_mul(ASEL_ONE, BSEL_BETA, DST_BASE);
                w.exp_ld  = EXPLD_GAM;
                w.acc_one = 1'b1;
            end
            5'd2: w = uc_jump(JC_EXPZ, PC_SEG2);
            5'd3: w = uc_jump(JC_EVEN, 5'd5);
            5'd4: w = uc_mul(ASEL_ACC, BSEL_BASE, DST_ACC);
            5'd5:
            begin
                w           = uc_mul(ASEL_BASE, BSEL_BASE, DST_BASE);
                w.exp_shift = 1'b1;
            end
            5'd6: w = uc_jump(JC_ALWAYS, PC_LOOP1);
            5'd7:
            begin
                w              = uc_mul(ASEL_ONE, BSEL_GAM, DST_BASE);
                w.exp_ld       = EXPLD_DEL;
                w.acc_one      = 1'b1;
                w.lhs_from_acc = 1'b1;
            end
            5'd8: w = uc_jump(JC_EXPZ, PC_COMB);
            5'd9: w = uc_jump(JC_EVEN, 5'd11);
            5'd10: w = uc_mul(ASEL_ACC, BSEL_BASE, DST_ACC);
            5'd11:
            begin
                w           = uc_mul(ASEL_BASE, BSEL_BASE, DST_BASE);
                w.exp_shift = 1'b1;
            end
            5'd12: w = uc_jump(JC_ALWAYS, PC_LOOP2);
            5'd13: w = uc_mul(ASEL_LHS, BSEL_ACC, DST_LHS);
            5'd14:
            begin
                w         = uc_mul(ASEL_ONE, BSEL_GEN, DST_BASE);
                w.exp_ld  = EXPLD_MSG;
                w.acc_one = 1'b1;
            end
            5'd15: w = uc_jump(JC_EXPZ, PC_CHECK);
            5'd16: w = uc_jump(JC_EVEN, 5'd18);
            5'd17: w = uc_mul(ASEL_ACC, BSEL_BASE, DST_ACC);
            5'd18:
            begin
                w           = uc_mul(ASEL_BASE, BSEL_BASE, DST_BASE);
                w.exp_shift = 1'b1;
            end
            5'd19: w = uc_jump(JC_ALWAYS, PC_LOOP3);
            5'd20: w = uc_fin(FIN_CHECK);
            default: w = uc_fin(FIN_REJECT);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/esv_ifs.sv
// Valid/ready channel interfaces for signature words and verdict words.
`default_nettype none

interface esv_item_if;
    logic                          valid;
    logic                          ready;
    logic [esv_pkg::FIELD_W-1:0]   message;
    logic [esv_pkg::FIELD_W-1:0]   sig_gamma;
    logic [esv_pkg::FIELD_W-1:0]   sig_delta;

    modport source (output valid, output message, output sig_gamma, output sig_delta,
                    input ready);
    modport sink (input valid, input message, input sig_gamma, input sig_delta,
                  output ready);
endinterface

interface esv_result_if;
    logic valid;
    logic ready;
    logic valid_res;

    modport source (output valid, output valid_res, input ready);
    modport sink (input valid, input valid_res, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/esv_modmul.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
`default_nettype none

`include "elgamal_signature_verify_top_macros.svh"

module esv_modmul #(
    parameter int W = esv_pkg::MOD_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    input  wire logic [W-1:0] p,
    output logic              done,
    output logic [W-1:0]      res
);

    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  p_reg;

    logic [W:0]    p_ext;
    logic [W:0]    dbl;
    logic [W:0]    dbl_red;
    logic [W:0]    sum;
    logic [W:0]    sum_red;
    logic [W-1:0]  r_next;

    // r = 2r mod p, then r = r + a mod p when the multiplier bit is set.
    always_comb
    begin
        p_ext   = {1'b0, p_reg};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= p_ext) ? dbl - p_ext : dbl;
        sum     = dbl_red + {1'b0, a_reg};
        sum_red = (sum >= p_ext) ? sum - p_ext : sum;
        r_next  = b_reg[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            a_reg <= a;
            b_reg <= b;
            p_reg <= p;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            b_reg <= {b_reg[W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign res  = r_reg;

    `ESV_ASSERT_IMP(a_no_restart, start, !busy_reg, "multiply started while busy")
    `ESV_ASSERT_IMP(a_partial_reduced, busy_reg, r_reg < p_reg, "partial product not reduced")
    `ESV_ASSERT_NXT(a_done_pulse, done_reg, !done_reg && !busy_reg, "done held or busy after done")

endmodule

`default_nettype wire

// File: hw/rtl/esv_core.sv
// Microcode sequencer and register datapath for the three exponentiations.
`default_nettype none

`include "elgamal_signature_verify_top_macros.svh"

module esv_core #(
    parameter int W = esv_pkg::MOD_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [W-1:0]      message,
    input  wire logic [W-1:0]      gamma,
    input  wire logic [W-1:0]      delta,
    input  wire logic [W-1:0]      p,
    input  wire logic [W-1:0]      g,
    input  wire logic [W-1:0]      beta,
    input  wire logic              out_free,
    output esv_pkg::core_stat_t    stat
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_MWAIT = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    esv_pkg::pc_t       pc_reg;
    esv_pkg::pc_t       pc_next;

    logic [W-1:0]       msg_reg;
    logic [W-1:0]       gam_reg;
    logic [W-1:0]       del_reg;
    logic [W-1:0]       acc_reg;
    logic [W-1:0]       base_reg;
    logic [W-1:0]       exp_reg;
    logic [W-1:0]       lhs_reg;

    esv_pkg::ucw_t      cw;
    logic               run;
    logic               bad_gam;
    logic               take;
    logic               mm_start;
    logic               mm_done;
    logic [W-1:0]       mm_a;
    logic [W-1:0]       mm_b;
    logic [W-1:0]       mm_res;
    logic               fin_fire;

    assign cw  = esv_pkg::ucode(pc_reg);
    assign run = (state_reg == ST_RUN);

    always_comb
    begin
        bad_gam = (gam_reg == '0) || (gam_reg >= p);

        case (cw.jc)
            esv_pkg::JC_ALWAYS: take = 1'b1;
            esv_pkg::JC_EXPZ:   take = (exp_reg == '0);
            esv_pkg::JC_EVEN:   take = !exp_reg[0];
            esv_pkg::JC_BADGAM: take = bad_gam;
            default:            take = 1'b0;
        endcase

        case (cw.a_sel)
            esv_pkg::ASEL_ACC:  mm_a = acc_reg;
            esv_pkg::ASEL_BASE: mm_a = base_reg;
            esv_pkg::ASEL_LHS:  mm_a = lhs_reg;
            default:            mm_a = W'(1);
        endcase

        case (cw.b_sel)
            esv_pkg::BSEL_GEN:  mm_b = g;
            esv_pkg::BSEL_GAM:  mm_b = gam_reg;
            esv_pkg::BSEL_BASE: mm_b = base_reg;
            esv_pkg::BSEL_ACC:  mm_b = acc_reg;
            default:            mm_b = beta;
        endcase
    end

    assign mm_start = run && cw.is_mul;
    assign fin_fire = run && !cw.is_mul && (cw.fin != esv_pkg::FIN_NONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    pc_next    = '0;
                end
            end
            ST_RUN:
            begin
                if (cw.is_mul)
                begin
                    state_next = ST_MWAIT;
                end
                else if (cw.fin != esv_pkg::FIN_NONE)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    pc_next = take ? cw.target : pc_reg + 1'b1;
                end
            end
            ST_MWAIT:
            begin
                if (mm_done)
                begin
                    state_next = ST_RUN;
                    pc_next    = pc_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    // Side actions of a multiply word happen as it issues; the multiplier
    // has already latched its operands from the old register values.
    always_ff @(posedge clk)
    begin
        if (start && (state_reg == ST_IDLE))
        begin
            msg_reg <= message;
            gam_reg <= gamma;
            del_reg <= delta;
        end

        if (mm_start)
        begin
            case (cw.exp_ld)
                esv_pkg::EXPLD_GAM: exp_reg <= gam_reg;
                esv_pkg::EXPLD_DEL: exp_reg <= del_reg;
                esv_pkg::EXPLD_MSG: exp_reg <= msg_reg;
                default:
                begin
                    if (cw.exp_shift)
                    begin
                        exp_reg <= exp_reg >> 1;
                    end
                end
            endcase
            if (cw.acc_one)
            begin
                acc_reg <= W'(1);
            end
            if (cw.lhs_from_acc)
            begin
                lhs_reg <= acc_reg;
            end
        end
        else if ((state_reg == ST_MWAIT) && mm_done)
        begin
            case (cw.dst)
                esv_pkg::DST_BASE: base_reg <= mm_res;
                esv_pkg::DST_LHS:  lhs_reg  <= mm_res;
                default:           acc_reg  <= mm_res;
            endcase
        end
    end

    esv_modmul #(
        .W (W)
    ) u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .a     (mm_a),
        .b     (mm_b),
        .p     (p),
        .done  (mm_done),
        .res   (mm_res)
    );

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = fin_fire;
    assign stat.ok   = (cw.fin == esv_pkg::FIN_CHECK) && (lhs_reg == acc_reg);

    `ESV_ASSERT_IMP(a_done_in_wait, mm_done, state_reg == ST_MWAIT, "product arrived outside wait")
    `ESV_ASSERT_IMP(a_fin_has_room, stat.done, out_free, "verdict issued with output full")
    `ESV_ASSERT_NXT(a_mul_waits, mm_start, state_reg == ST_MWAIT, "multiply issued without wait")

endmodule

`default_nettype wire

// File: hw/rtl/elgamal_signature_verify_top.sv
// Top level of the signature verifier: key registers, core and verdict register.
//
// Usage: write the modulus, generator and public value through the plain write
// port (index 0, 1, 2; other indexes are ignored) while the block is idle.
// Each word on the item channel carries message, sig_gamma and sig_delta; the
// block answers each with one result word, valid_res = 1 when gamma is nonzero,
// below the modulus and beta^gamma * gamma^delta equals g^message mod modulus.
// A word is taken when item.ready is high, which is whenever the sequencer is
// idle, even while the previous verdict still waits in the output register.
// A gamma of zero or not below the modulus is rejected by the first step,
// before any modular product; otherwise the lengths and set bits of the three
// exponents set how long the verdict takes. Every modular product runs in the
// bit-serial multiplier, and the block works on one item at a time, the next
// word being taken at the earliest in the cycle its predecessor's verdict
// appears. Reset loads modulus 2, generator 0 and public value 0 and empties
// the output register. When the receiver stalls, the verdict holds in the
// output register and the sequencer waits at its last step until it frees.
`default_nettype none

module elgamal_signature_verify_top #(
    parameter int MOD_BITS = esv_pkg::MOD_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [esv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [esv_pkg::FIELD_W-1:0]     cfg_wdata,
    esv_item_if.sink                             item,
    esv_result_if.source                         result
);

    localparam int EW = esv_pkg::FIELD_W + MOD_BITS;

    logic [esv_pkg::FIELD_W-1:0] modulus_reg;
    logic [esv_pkg::FIELD_W-1:0] generator_reg;
    logic [esv_pkg::FIELD_W-1:0] public_value_reg;
    logic                        res_valid_reg;
    logic                        res_ok_reg;

    logic [EW-1:0]       m_ext;
    logic [EW-1:0]       gam_ext;
    logic [EW-1:0]       del_ext;
    logic [EW-1:0]       p_ext;
    logic [EW-1:0]       g_ext;
    logic [EW-1:0]       beta_ext;
    logic                out_free;
    logic                start;
    esv_pkg::core_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg      <= esv_pkg::MODULUS_RST;
            generator_reg    <= '0;
            public_value_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                esv_pkg::REG_MODULUS:      modulus_reg      <= cfg_wdata;
                esv_pkg::REG_GENERATOR:    generator_reg    <= cfg_wdata;
                esv_pkg::REG_PUBLIC_VALUE: public_value_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Operands keep only their low MOD_BITS bits.
    assign m_ext    = EW'(item.message);
    assign gam_ext  = EW'(item.sig_gamma);
    assign del_ext  = EW'(item.sig_delta);
    assign p_ext    = EW'(modulus_reg);
    assign g_ext    = EW'(generator_reg);
    assign beta_ext = EW'(public_value_reg);

    assign item.ready = stat.idle;
    assign start      = item.valid && stat.idle;
    assign out_free   = !res_valid_reg || result.ready;

    esv_core #(
        .W (MOD_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .message  (m_ext[MOD_BITS-1:0]),
        .gamma    (gam_ext[MOD_BITS-1:0]),
        .delta    (del_ext[MOD_BITS-1:0]),
        .p        (p_ext[MOD_BITS-1:0]),
        .g        (g_ext[MOD_BITS-1:0]),
        .beta     (beta_ext[MOD_BITS-1:0]),
        .out_free (out_free),
        .stat     (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            res_ok_reg <= stat.ok;
        end
    end

    assign result.valid     = res_valid_reg;
    assign result.valid_res = res_ok_reg;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the ElGamal signature verifier top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [esv_pkg::FIELD_W-1:0] word_t;

    localparam longint unsigned WORD_MAX = 64'h7FFF_FFFF;
    localparam logic [esv_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_PHASES = 5;
    localparam int WORDS_PER_PHASE = 20;
    localparam int DRAIN_CYCLES = 100;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [esv_pkg::CFG_IDX_W-1:0] cfg_index;
    word_t cfg_wdata;

    esv_item_if item_ch ();
    esv_result_if result_ch ();

    // Key registers as the block should hold them.
    word_t key_modulus;
    word_t key_generator;
    word_t key_public;

    bit pending_verdicts[$];
    bit expected_verdict;
    bit idling_on = 1'b1;
    int mismatch_count = 0;
    int words_sent = 0;
    int verifying_words = 0;
    int key_settings = 0;
    int cycle_count = 0;

    elgamal_signature_verify_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                                longint unsigned p);
        return (a * b) % p;
    endfunction

    function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned e,
                                                longint unsigned p);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1;
        sq = base % p;
        while (e != 0)
        begin
            if (e[0])
                acc = mul_mod(acc, sq, p);
            e = e >> 1;
            sq = mul_mod(sq, sq, p);
        end
        return acc % p;
    endfunction

    // Verdict for one signature word under the current key registers.
    function automatic bit predict_verdict(word_t msg, word_t gam, word_t del);
        longint unsigned p;
        longint unsigned lhs;
        longint unsigned rhs;
        p = key_modulus;
        if (gam == 0 || gam >= p)
            return 1'b0;
        lhs = mul_mod(pow_mod(key_public, gam, p), pow_mod(gam, del, p), p);
        rhs = pow_mod(key_generator, msg, p);
        return lhs == rhs;
    endfunction

    // Adds a random multiple of step while the value still fits a field.
    function automatic longint unsigned lift_residue(longint unsigned v, longint unsigned step);
        longint unsigned span;
        span = (WORD_MAX - v) / step;
        if ($urandom_range(0, 1) == 0)
            return v;
        return v + step * $urandom_range(0, span);
    endfunction

    function automatic longint unsigned pick_prime(int unsigned sel);
        case (sel)
            0: return 2;
            1: return 3;
            2: return 13;
            3: return 65537;
            4: return 1000003;
            5: return 2147483629;
            default: return WORD_MAX;
        endcase
    endfunction

    // A well-formed signature: gamma = g^k, message = a*gamma + k*delta mod (p-1).
    task automatic build_signature(input longint unsigned p, input longint unsigned g,
                                   input longint unsigned priv, input word_t del,
                                   output word_t msg, output word_t gam);
        longint unsigned nonce;
        longint unsigned exp_sum;
        nonce = $urandom_range(1, p - 1);
        gam = word_t'(pow_mod(g, nonce, p));
        exp_sum = (priv * gam + nonce * del) % (p - 1);
        msg = word_t'(lift_residue(exp_sum, p - 1));
    endtask

    task automatic write_key_reg(input logic [esv_pkg::CFG_IDX_W-1:0] idx, input word_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            esv_pkg::REG_MODULUS: key_modulus = value;
            esv_pkg::REG_GENERATOR: key_generator = value;
            esv_pkg::REG_PUBLIC_VALUE: key_public = value;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_key(input longint unsigned p, input longint unsigned g,
                            input longint unsigned beta);
        write_key_reg(esv_pkg::REG_MODULUS, word_t'(p));
        write_key_reg(esv_pkg::REG_GENERATOR, word_t'(g));
        write_key_reg(esv_pkg::REG_PUBLIC_VALUE, word_t'(beta));
        key_settings++;
    endtask

    // Holds the item channel quiet until every pending verdict has come back.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_verdicts.size() != 0);
    endtask

    task automatic send_signature(input word_t msg, input word_t gam, input word_t del);
        bit verdict;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        verdict = predict_verdict(msg, gam, del);
        item_ch.valid <= 1'b1;
        item_ch.message <= msg;
        item_ch.sig_gamma <= gam;
        item_ch.sig_delta <= del;
        do
        begin
            @(posedge clk);
        end
        while (!item_ch.ready);
        pending_verdicts.push_back(verdict);
        words_sent++;
        if (verdict)
            verifying_words++;
    endtask

    // The reset key is p = 2, g = 0, beta = 0.
    task automatic test_reset_key();
        send_signature(word_t'(0), word_t'(1), word_t'(0));
        send_signature(word_t'(1), word_t'(1), word_t'(1));
        send_signature(word_t'(1), word_t'(2), word_t'(1));
    endtask

    task automatic test_key_extremes();
        longint unsigned priv;
        word_t msg;
        word_t gam;
        wait_drained();
        priv = 123456789;
        load_key(WORD_MAX, 7, pow_mod(7, priv, WORD_MAX));
        send_signature(word_t'($urandom), word_t'(0), word_t'($urandom));
        send_signature(word_t'($urandom), word_t'(WORD_MAX), word_t'($urandom));
        send_signature(word_t'(0), word_t'(WORD_MAX - 1), word_t'(0));
        build_signature(WORD_MAX, 7, priv, word_t'(WORD_MAX), msg, gam);
        send_signature(msg, gam, word_t'(WORD_MAX));
        build_signature(WORD_MAX, 7, priv, word_t'(0), msg, gam);
        send_signature(msg, gam, word_t'(0));
        send_signature(word_t'(WORD_MAX), gam, word_t'(0));
        send_signature(word_t'(0), word_t'(1), word_t'(WORD_MAX));
        // Generator and public value equal to p reduce to zero.
        wait_drained();
        load_key(WORD_MAX, WORD_MAX, WORD_MAX);
        send_signature(word_t'(0), word_t'(5), word_t'(0));
        send_signature(word_t'(3), word_t'(5), word_t'(0));
    endtask

    task automatic test_short_modulus();
        longint unsigned priv;
        word_t msg;
        word_t gam;
        word_t del;
        wait_drained();
        load_key(0, 5, 5);
        send_signature(word_t'(1), word_t'(1), word_t'(1));
        send_signature(word_t'(0), word_t'(0), word_t'(0));
        wait_drained();
        load_key(1, 0, 0);
        send_signature(word_t'(0), word_t'(1), word_t'(0));
        // A write to the unused index must leave a working key untouched.
        wait_drained();
        priv = 5;
        load_key(13, 2, pow_mod(2, priv, 13));
        write_key_reg(REG_UNUSED, word_t'(0));
        del = word_t'($urandom);
        build_signature(13, 2, priv, del, msg, gam);
        send_signature(msg, gam, del);
        del = word_t'($urandom);
        build_signature(13, 2, priv, del, msg, gam);
        send_signature(msg, gam, del);
    endtask

    task automatic test_unreduced_key();
        longint unsigned priv;
        word_t msg;
        word_t gam;
        word_t del;
        wait_drained();
        priv = 7;
        load_key(11, 2 + 11 * 190000000, pow_mod(2, priv, 11) + 11 * 123456);
        del = word_t'($urandom);
        build_signature(11, 2, priv, del, msg, gam);
        send_signature(msg, gam, del);
        send_signature(msg + word_t'(1), gam, del);
        del = word_t'($urandom);
        build_signature(11, 2, priv, del, msg, gam);
        send_signature(msg, gam, del);
    endtask

    task automatic test_random_signatures();
        longint unsigned p;
        longint unsigned g_red;
        longint unsigned priv;
        word_t msg;
        word_t gam;
        word_t del;
        int unsigned bit_pos;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            if (phase == RANDOM_PHASES - 1)
                idling_on = 1'b0;
            p = pick_prime($urandom_range(0, 6));
            g_red = $urandom_range(1, p - 1);
            priv = $urandom;
            load_key(p, lift_residue(g_red, p), lift_residue(pow_mod(g_red, priv, p), p));
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                del = word_t'($urandom);
                build_signature(p, g_red, priv, del, msg, gam);
                bit_pos = $urandom_range(0, esv_pkg::FIELD_W - 1);
                case ($urandom_range(0, 9))
                    0:
                    begin
                        msg = word_t'($urandom);
                        gam = word_t'($urandom);
                        del = word_t'($urandom);
                    end
                    1: msg[bit_pos] = ~msg[bit_pos];
                    2: gam[bit_pos] = ~gam[bit_pos];
                    3: del[bit_pos] = ~del[bit_pos];
                    4: gam = ($urandom_range(0, 1) == 0) ? word_t'(0) : word_t'(p);
                    default: ;
                endcase
                send_signature(msg, gam, del);
            end
        end
    endtask

    // Result side: random stall bursts while idling is on.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 4) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("valid_res: word with no verdict pending, expected none, actual %0b",
                       result_ch.valid_res);
                mismatch_count++;
            end
            else
            begin
                expected_verdict = pending_verdicts.pop_front();
                if (result_ch.valid_res !== expected_verdict)
                begin
                    $error("valid_res mismatch: expected %0b, actual %0b",
                           expected_verdict, result_ch.valid_res);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("elgamal_signature_verify_top verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = esv_pkg::REG_MODULUS;
        cfg_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.message = '0;
        item_ch.sig_gamma = '0;
        item_ch.sig_delta = '0;
        key_modulus = esv_pkg::MODULUS_RST;
        key_generator = '0;
        key_public = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_key();
        test_key_extremes();
        test_short_modulus();
        test_unreduced_key();
        test_random_signatures();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d signature words under %0d key settings, %0d expected to verify.",
                 words_sent, key_settings, verifying_words);
        $display("Included bad gammas, moduli below two, unreduced keys and an unused index.");
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("elgamal_signature_verify_top verification clean");
        else
            $display("elgamal_signature_verify_top verification failed");
        $finish;
    end

endmodule
